>>> sv/mcs_pkg.sv
// Package for the markup comment stripper: opener and closer characters and the result plan type.
package mcs_pkg;

   localparam logic [7:0] CHAR_LT   = 8'h3C;  // '<'
   localparam logic [7:0] CHAR_BANG = 8'h21;  // '!'
   localparam logic [7:0] CHAR_DASH = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'

   // Results caused by one input word: a prefix of the opener, then optionally
   // the input byte itself, or a bare end marker.
   typedef struct packed {
      logic [1:0] prefix_len;  // held opener bytes to emit, 0..3
      logic       tail;        // emit the input byte after the prefix
      logic       marker;      // emit one bare end marker
      logic [7:0] data;        // the input byte
      logic       last;        // final word of the document
   } plan_type;

   // Byte at a given position of the opener "<!--".
   function automatic logic [7:0] opener_byte(input logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = CHAR_LT;
         2'd1:    ch = CHAR_BANG;
         default: ch = CHAR_DASH;
      endcase
      return ch;
   endfunction

endpackage

>>> sv/markup_comment_stripper.sv
// Top level of the markup comment stripper: input handshake, result buffer and output channel.
//
//   channel  direction  tdata                            tuser        tlast
//   req_     in         [7:0] in_byte                    -            doc_last
//   rsp_     out        [7:0] out_byte, [8] run_last     byte_valid   doc_end
//
// One input word per cycle while the output is not stalled, when it causes at most one result; a word
// that causes more results (up to four: flushed opener bytes plus the byte) holds the input while the
// result buffer drains, one result per cycle while the output is not stalled.
// Results are presented from a registered buffer in the cycle after the word is taken.
// Reset (synchronous) clears the parse state and empties the buffer.
// Output stalls hold the buffer; the input is taken when the buffer is empty or its last result leaves.
module markup_comment_stripper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // doc_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast    // doc_end
);

   mcs_pkg::plan_type plan;
   logic       req_fire, rsp_fire;
   logic [2:0] remain_ff, remain_in;
   logic [1:0] index_ff, index_in;
   logic [1:0] prefix_ff;
   logic       marker_ff, last_ff;
   logic [7:0] data_ff;
   logic [7:0] out_byte;
   logic       run_last;

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (remain_ff == 3'd0) || (remain_ff == 3'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   mcs_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_fire),
      .in_byte  (req_tdata),
      .doc_last (req_tlast),
      .plan     (plan)
   );

   // Load a new plan on accept, advance on each delivered word
   always_comb begin
      remain_in = remain_ff;
      index_in  = index_ff;
      if (req_fire) begin
         remain_in = {1'b0, plan.prefix_len} + {2'b00, plan.tail} + {2'b00, plan.marker};
         index_in  = 2'd0;
      end else if (rsp_fire) begin
         remain_in = remain_ff - 3'd1;
         index_in  = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= 3'd0;
         index_ff  <= 2'd0;
      end else begin
         remain_ff <= remain_in;
         index_ff  <= index_in;
      end
   end

   // Hold the payload of the plan being drained
   always_ff @(posedge clock) begin
      if (req_fire) begin
         prefix_ff <= plan.prefix_len;
         marker_ff <= plan.marker;
         last_ff   <= plan.last;
         data_ff   <= plan.data;
      end
   end

   // Select the current result
   always_comb begin
      if (index_ff < prefix_ff) begin
         out_byte = mcs_pkg::opener_byte(index_ff);
      end else if (marker_ff) begin
         out_byte = 8'd0;
      end else begin
         out_byte = data_ff;
      end
      run_last = (remain_ff == 3'd1);
   end

   assign rsp_tvalid = (remain_ff != 3'd0);
   assign rsp_tdata  = {7'd0, run_last, out_byte};
   assign rsp_tuser  = !marker_ff;
   assign rsp_tlast  = last_ff && run_last;

endmodule

>>> sv/mcs_scan.sv
// Opener and closer matcher: holds the parse state and plans the results of each word.
module mcs_scan (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                doc_last,
   output mcs_pkg::plan_type   plan
);

   logic       in_comment_ff, in_comment_in;
   logic [1:0] matched_ff, matched_in;
   logic [1:0] dashes_ff, dashes_in;
   logic       hit;

   // Decide the results and the next parse state
   always_comb begin
      hit             = (in_byte == mcs_pkg::opener_byte(matched_ff));
      in_comment_in   = in_comment_ff;
      matched_in      = matched_ff;
      dashes_in       = dashes_ff;
      plan.prefix_len = 2'd0;
      plan.tail       = 1'b0;
      plan.data       = in_byte;
      plan.last       = doc_last;
      if (in_comment_ff) begin
         if (in_byte == mcs_pkg::CHAR_DASH) begin
            if (dashes_ff != 2'd2) begin
               dashes_in = dashes_ff + 2'd1;
            end
         end else if (in_byte == mcs_pkg::CHAR_GT && dashes_ff == 2'd2) begin
            in_comment_in = 1'b0;
            dashes_in     = 2'd0;
         end else begin
            dashes_in = 2'd0;
         end
      end else if (hit) begin
         if (matched_ff == 2'd3) begin
            matched_in    = 2'd0;
            in_comment_in = 1'b1;
            dashes_in     = 2'd0;
         end else begin
            matched_in = matched_ff + 2'd1;
            // flush the grown partial opener on the final word
            if (doc_last) begin
               plan.prefix_len = matched_ff + 2'd1;
            end
         end
      end else begin
         // failed match: emit held bytes, then the byte unless it starts a new match on a non-final word
         plan.prefix_len = matched_ff;
         plan.tail       = (in_byte != mcs_pkg::CHAR_LT) || doc_last;
         matched_in      = (in_byte == mcs_pkg::CHAR_LT) ? 2'd1 : 2'd0;
      end
      plan.marker = doc_last && (plan.prefix_len == 2'd0) && !plan.tail;
   end

   // Advance the parse state; return to reset after the final word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         matched_ff    <= 2'd0;
         dashes_ff     <= 2'd0;
      end else if (accept) begin
         if (doc_last) begin
            in_comment_ff <= 1'b0;
            matched_ff    <= 2'd0;
            dashes_ff     <= 2'd0;
         end else begin
            in_comment_ff <= in_comment_in;
            matched_ff    <= matched_in;
            dashes_ff     <= dashes_in;
         end
      end
   end

endmodule

>>> bench/testbench.sv
// Self-checking testbench for markup_comment_stripper: byte stream in, comment-free words out.
module testbench;

   // Opener "<!--" packed with its first character in the lowest byte
   localparam logic [31:0] OPENER      = {mcs_pkg::CHAR_DASH, mcs_pkg::CHAR_DASH,
                                          mcs_pkg::CHAR_BANG, mcs_pkg::CHAR_LT};
   localparam int          TOTAL_WORDS = 250;
   localparam int          TAIL_WORDS  = 40;
   localparam int          HOLD_CYCLES = 60;
   localparam int          STALL_LIMIT = 1000;
   localparam int          DRAIN_WAIT  = 20;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } doc_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       run_last;
      logic       doc_end;
   } kept_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] in_byte
   logic        req_tlast  = 1'b0; // doc_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] out_byte, [8] run_last, [15:9] zero
   logic        rsp_tuser;         // [0] byte_valid
   logic        rsp_tlast;         // doc_end

   doc_word_type  doc_bytes_q [$];
   kept_word_type kept_q [$];

   // Stripper state as the bench sees it
   logic       in_cmt   = 1'b0;
   logic [1:0] held_cnt = '0;
   logic [1:0] dash_cnt = '0;

   int  words_taken     = 0;
   int  docs_taken      = 0;
   int  results_seen    = 0;
   int  comments_opened = 0;
   int  comments_closed = 0;
   int  mismatches      = 0;
   int  quiet_cycles    = 0;
   int  gap_left        = 0;
   int  stall_left      = 0;
   logic tail_phase     = 1'b0;
   logic hold_off       = 1'b0;

   markup_comment_stripper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the words that one input byte causes and queue them
   task automatic strip_word(input logic [7:0] b, input logic last);
      kept_word_type res [$];
      int            i;
      if (in_cmt) begin
         if (b == mcs_pkg::CHAR_DASH) begin
            if (dash_cnt < 2) dash_cnt++;
         end else if (b == mcs_pkg::CHAR_GT && dash_cnt == 2) begin
            in_cmt   = 1'b0;
            dash_cnt = '0;
            comments_closed++;
         end else begin
            dash_cnt = '0;
         end
      end else if (b == OPENER[held_cnt*8 +: 8]) begin
         if (held_cnt == 3) begin
            held_cnt = '0;
            in_cmt   = 1'b1;
            dash_cnt = '0;
            comments_opened++;
         end else begin
            held_cnt++;
         end
      end else begin
         // Release the held opener prefix, then look at the byte afresh
         for (i = 0; i < held_cnt; i++) res.push_back('{OPENER[i*8 +: 8], 1'b1, 1'b0, 1'b0});
         held_cnt = '0;
         if (b == mcs_pkg::CHAR_LT) held_cnt = 2'd1;
         else res.push_back('{b, 1'b1, 1'b0, 1'b0});
      end

      if (last) begin
         if (!in_cmt) begin
            for (i = 0; i < held_cnt; i++) res.push_back('{OPENER[i*8 +: 8], 1'b1, 1'b0, 1'b0});
         end
         if (res.size() == 0) res.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         res[res.size()-1].doc_end = 1'b1;
         in_cmt   = 1'b0;
         held_cnt = '0;
         dash_cnt = '0;
      end

      if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
      foreach (res[k]) kept_q.push_back(res[k]);
   endtask

   task automatic add_text(input string s, input logic last);
      int i;
      for (i = 0; i < s.len(); i++) doc_bytes_q.push_back('{s[i], last && (i == s.len()-1)});
   endtask

   task automatic add_byte(input logic [7:0] b, input logic last);
      doc_bytes_q.push_back('{b, last});
   endtask

   function automatic logic [7:0] pick_markup();
      logic [7:0] ch;
      case ($urandom_range(0, 3))
         0:       ch = mcs_pkg::CHAR_LT;
         1:       ch = mcs_pkg::CHAR_BANG;
         2:       ch = mcs_pkg::CHAR_DASH;
         default: ch = mcs_pkg::CHAR_GT;
      endcase
      return ch;
   endfunction

   // Build one document from plain text, comments, broken openers and dash runs
   task automatic add_random_doc();
      logic [7:0] doc [$];
      int         target;
      int         n;
      int         i;
      target = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(3, 20);
      while (doc.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: repeat ($urandom_range(1, 4)) doc.push_back(8'($urandom_range(0, 255)));
            4: doc.push_back(pick_markup());
            5, 6: begin
               for (i = 0; i < 4; i++) doc.push_back(OPENER[i*8 +: 8]);
               repeat ($urandom_range(0, 6)) begin
                  if ($urandom_range(0, 1) == 1) doc.push_back(pick_markup());
                  else doc.push_back(8'($urandom_range(0, 255)));
               end
               repeat ($urandom_range(2, 3)) doc.push_back(mcs_pkg::CHAR_DASH);
               doc.push_back(mcs_pkg::CHAR_GT);
            end
            7: begin
               n = $urandom_range(1, 3);
               for (i = 0; i < n; i++) doc.push_back(OPENER[i*8 +: 8]);
               if ($urandom_range(0, 1) == 1) doc.push_back(pick_markup());
               else doc.push_back(8'($urandom_range(0, 255)));
            end
            8: for (i = 0; i < 4; i++) doc.push_back(OPENER[i*8 +: 8]);
            default: begin
               repeat ($urandom_range(1, 4)) doc.push_back(mcs_pkg::CHAR_DASH);
               doc.push_back(mcs_pkg::CHAR_GT);
            end
         endcase
      end
      foreach (doc[k]) doc_bytes_q.push_back('{doc[k], k == doc.size()-1});
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Hold reset at the start of the run, then release it
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Input driver: offer queued bytes, keep valid up until taken, idle in short bursts
   always @(posedge clock) begin : feed
      logic         offer;
      doc_word_type nxt;
      offer = 1'b0;
      nxt   = '0;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         gap_left    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            strip_word(req_tdata, req_tlast);
            void'(doc_bytes_q.pop_front());
            words_taken <= words_taken + 1;
            if (req_tlast) docs_taken <= docs_taken + 1;
         end
         tail_phase <= (doc_bytes_q.size() < TAIL_WORDS);

         if (req_tvalid && !req_tready) begin
            offer = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (doc_bytes_q.size() != 0) begin
            if (!tail_phase && $urandom_range(0, 7) == 0) gap_left = $urandom_range(0, 3);
            else offer = 1'b1;
         end

         if (offer) nxt = doc_bytes_q[0];
         req_tvalid <= offer;
         req_tdata  <= nxt.ch;
         req_tlast  <= nxt.last;
      end
   end

   // Output monitor: compare each word with the oldest expectation, stall at random
   always @(posedge clock) begin : watch
      kept_word_type want;
      logic          rdy;
      rdy = 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (kept_q.size() == 0) begin
               $error("unexpected word: out_byte %0h, byte_valid %0b, doc_end %0b",
                      rsp_tdata[7:0], rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = kept_q.pop_front();
               check_field("out_byte",   want.out_byte,   rsp_tdata[7:0]);
               check_field("byte_valid", {7'b0, want.byte_valid}, {7'b0, rsp_tuser});
               check_field("run_last",   {7'b0, want.run_last},   {7'b0, rsp_tdata[8]});
               check_field("doc_end",    {7'b0, want.doc_end},    {7'b0, rsp_tlast});
               results_seen++;
            end
         end

         if (hold_off) begin
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (!tail_phase && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 3);
         end else begin
            rdy = 1'b1;
         end
         rsp_tready <= rdy;
      end
   end

   // Long receiver hold-off partway through so the block backs up into its input
   initial begin
      while (words_taken < 90) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and end of run
   initial begin
      // Opener dashes do not close, a long dash run does, then both byte extremes
      add_text("a<!-->b--->", 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'hFF, 1'b1);
      // Broken opener after three held bytes, a restarting '<', held bytes flushed at the end
      add_text("<!-Z<<!", 1'b1);
      // Unterminated comment gives only the bare end marker
      add_text("<!--q", 1'b1);

      while (doc_bytes_q.size() < TOTAL_WORDS) add_random_doc();

      while (doc_bytes_q.size() != 0 || kept_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Streamed %0d bytes in %0d documents and checked %0d output words",
               words_taken, docs_taken, results_seen);
      $display("Predicted %0d comments opened and %0d closed, with a long output hold-off",
               comments_opened, comments_closed);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
